[hw/rtl/hcs_pkg.sv]
// shared types and constants for the histogram contrast stretch block
// no dependencies
`timescale 1ns / 1ps

package hcs_pkg;

    localparam int PIX_W   = 8;
    localparam int COUNT_W = 24;
    localparam int NUM_W   = 17;
    localparam int DEN_W   = 9;
    localparam int QUO_W   = 8;
    localparam int STEP_W  = 3;

    localparam logic [PIX_W-1:0] PIX_MIN = '0;
    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MAP  = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // edges of the current histogram pass
    typedef struct packed {
        pix_t low;
        pix_t high;
        logic any;
    } edges_t;

    // divider handshake towards the sequencer
    typedef struct packed {
        logic            done;
        logic [QUO_W-1:0] quotient;
    } div_status_t;

endpackage

[hw/rtl/hcs_edges.sv]
// histogram edge tracker: first and last occupied bin of the current pass
// depends on hcs_pkg
`timescale 1ns / 1ps

module hcs_edges
    import hcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [COUNT_W-1:0] bin_count,
    output edges_t             edges
);

    pix_t bin_pos_reg;
    pix_t bin_pos_next;
    pix_t low_reg;
    pix_t low_next;
    pix_t high_reg;
    pix_t high_next;
    logic any_reg;
    logic any_next;
    logic any_eff;

    always_comb
    begin
        bin_pos_next = bin_pos_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        any_next     = any_reg;
        // bin zero opens a new pass
        any_eff      = (bin_pos_reg == PIX_MIN) ? 1'b0 : any_reg;
        if (load)
        begin
            any_next = any_eff;
            if (bin_count != '0)
            begin
                if (!any_eff)
                begin
                    low_next = bin_pos_reg;
                end
                high_next = bin_pos_reg;
                any_next  = 1'b1;
            end
            bin_pos_next = bin_pos_reg + PIX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_pos_reg <= '0;
            low_reg     <= '0;
            high_reg    <= '0;
            any_reg     <= 1'b0;
        end
        else
        begin
            bin_pos_reg <= bin_pos_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            any_reg     <= any_next;
        end
    end

    assign edges.low  = low_reg;
    assign edges.high = high_reg;
    assign edges.any  = any_reg;

endmodule

[hw/rtl/hcs_divider.sv]
// restoring divider, one quotient bit per cycle, quotient known below 256
// depends on hcs_pkg
`timescale 1ns / 1ps

module hcs_divider
    import hcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output div_status_t      status
);

    logic              active_reg;
    logic              active_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [QUO_W-1:0]  bits_reg;
    logic [QUO_W-1:0]  bits_next;
    logic [QUO_W-1:0]  quo_reg;
    logic [QUO_W-1:0]  quo_next;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  den_next;
    logic [DEN_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, bits_reg[QUO_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        rem_next    = rem_reg;
        bits_next   = bits_reg;
        quo_next    = quo_reg;
        den_next    = den_reg;
        if (start)
        begin
            active_next = 1'b1;
            step_next   = '0;
            rem_next    = numer[NUM_W-1:QUO_W];
            bits_next   = numer[QUO_W-1:0];
            quo_next    = '0;
            den_next    = denom;
        end
        else if (active_reg)
        begin
            rem_next  = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            bits_next = {bits_reg[QUO_W-2:0], 1'b0};
            quo_next  = {quo_reg[QUO_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == '1)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
    end

    assign status.done     = done_reg;
    assign status.quotient = quo_reg;

endmodule

[hw/rtl/histogram_contrast_stretch_top.sv]
// top level: command port, map sequencer, edge tracker and divider
// depends on hcs_pkg, hcs_edges, hcs_divider
`timescale 1ns / 1ps

// Linear contrast stretch of 8-bit pixels. A load beat (cmd 0) takes one bin
// count in bin order and is absorbed without leaving idle, so busy stays low and
// loads may follow back to back. A map beat (cmd 1) raises busy and produces one
// mapped_pixel, shown with done high for exactly one cycle; the receiver cannot
// stall it. Pixels outside the edges, an empty histogram or a single occupied
// bin are resolved in the setup state; all others go from the setup state to
// the one-bit-per-cycle restoring divider and take its quotient as the result.
// No new beat is taken while busy, so each map beat finishes before the next.

module histogram_contrast_stretch_top
    import hcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [COUNT_W-1:0] bin_count,
    input  logic [PIX_W-1:0]   pixel,
    output logic               done,
    output logic [PIX_W-1:0]   mapped_pixel
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    pix_t             pix_reg;
    pix_t             pix_next;
    pix_t             out_reg;
    pix_t             out_next;
    logic             done_reg;
    logic             done_next;
    logic             accept;
    logic             load;
    logic             div_start;
    edges_t           edges;
    div_status_t      div_status;
    pix_t             offset;
    pix_t             span;
    logic [NUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;

    assign accept = start && (state_reg == ST_IDLE);
    assign load   = accept && (cmd == CMD_LOAD);

    hcs_edges u_edges (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .bin_count (bin_count),
        .edges     (edges)
    );

    // 510*d + span over 2*span
    assign offset = pix_reg - edges.low;
    assign span   = edges.high - edges.low;
    assign numer  = ({offset, 9'b0} - {8'b0, offset, 1'b0}) + {9'b0, span};
    assign denom  = {span, 1'b0};

    hcs_divider u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .numer  (numer),
        .denom  (denom),
        .status (div_status)
    );

    always_comb
    begin
        state_next = state_reg;
        pix_next   = pix_reg;
        out_next   = out_reg;
        done_next  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_MAP))
                begin
                    pix_next   = pixel;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (!edges.any || (pix_reg < edges.low) || (span == '0 && pix_reg == edges.low))
                begin
                    out_next   = PIX_MIN;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (pix_reg > edges.high)
                begin
                    out_next   = PIX_MAX;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    out_next   = div_status.quotient;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        out_reg <= out_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign mapped_pixel = out_reg;

endmodule

[tb/histogram_contrast_stretch_top_tb.sv]
`timescale 1ns / 1ps
// testbench for histogram_contrast_stretch_top: directed table of load and map beats,
// then random histogram passes with maps checked against a local edge predictor
// depends on hcs_pkg and histogram_contrast_stretch_top

module histogram_contrast_stretch_top_tb;
    import hcs_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1370;
    localparam int TAIL_CYCLES  = 24;
    localparam int NUM_ROWS     = 27;

    typedef struct packed {
        logic               cmd;
        logic [COUNT_W-1:0] count;
        pix_t               pix;
        int                 reps;
        bit                 typed;
        pix_t               want;
    } beat_row_t;

    // cmd, bin_count, pixel, repeats, typed result, result
    localparam beat_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{CMD_MAP,  24'h000000, 8'd0,   1,   1'b1, 8'd0},
        '{CMD_MAP,  24'hFFFFFF, 8'd255, 1,   1'b1, 8'd0},
        '{CMD_LOAD, 24'hFFFFFF, 8'hAA,  1,   1'b0, 8'd0},
        '{CMD_MAP,  24'h000000, 8'd0,   1,   1'b1, 8'd0},
        '{CMD_MAP,  24'h000000, 8'd1,   1,   1'b1, 8'd255},
        '{CMD_LOAD, 24'h000001, 8'd0,   1,   1'b0, 8'd0},
        '{CMD_MAP,  24'h000000, 8'd1,   1,   1'b1, 8'd255},
        '{CMD_MAP,  24'h000000, 8'd0,   1,   1'b1, 8'd0},
        '{CMD_LOAD, 24'h000000, 8'hFF,  253, 1'b0, 8'd0},
        '{CMD_LOAD, 24'h800000, 8'd0,   1,   1'b0, 8'd0},
        '{CMD_MAP,  24'h000000, 8'd128, 1,   1'b0, 8'd0},
        '{CMD_MAP,  24'h000000, 8'd255, 1,   1'b1, 8'd255},
        '{CMD_MAP,  24'h000000, 8'd0,   1,   1'b1, 8'd0},
        '{CMD_LOAD, 24'h000000, 8'd0,   1,   1'b0, 8'd0},
        '{CMD_MAP,  24'h000000, 8'd5,   1,   1'b1, 8'd0},
        '{CMD_LOAD, 24'h000000, 8'd0,   99,  1'b0, 8'd0},
        '{CMD_LOAD, 24'h000005, 8'd0,   1,   1'b0, 8'd0},
        '{CMD_MAP,  24'h000000, 8'd100, 1,   1'b1, 8'd0},
        '{CMD_MAP,  24'h000000, 8'd99,  1,   1'b1, 8'd0},
        '{CMD_MAP,  24'h000000, 8'd101, 1,   1'b1, 8'd255},
        '{CMD_LOAD, 24'h000000, 8'd0,   99,  1'b0, 8'd0},
        '{CMD_LOAD, 24'h000007, 8'd0,   1,   1'b0, 8'd0},
        '{CMD_MAP,  24'h000000, 8'd150, 1,   1'b0, 8'd0},
        '{CMD_MAP,  24'h000000, 8'd99,  1,   1'b1, 8'd0},
        '{CMD_MAP,  24'h000000, 8'd201, 1,   1'b1, 8'd255},
        '{CMD_LOAD, 24'h000000, 8'd0,   55,  1'b0, 8'd0},
        '{CMD_MAP,  24'h000000, 8'd200, 1,   1'b1, 8'd255}
    };

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               cmd       = CMD_LOAD;
    logic [COUNT_W-1:0] bin_count = '0;
    pix_t               pixel     = '0;
    logic               busy;
    logic               done;
    pix_t               mapped_pixel;

    // predictor copy of the histogram pass
    pix_t hist_pos  = '0;
    pix_t edge_lo   = '0;
    pix_t edge_hi   = '0;
    logic edge_seen = 1'b0;

    pix_t pending_pixels [$];
    int   error_count  = 0;
    int   map_count    = 0;
    int   load_count   = 0;
    int   result_count = 0;
    int   idle_cycles  = 0;
    int   passes_done  = 0;
    bit   burst        = 1'b0;

    histogram_contrast_stretch_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .bin_count    (bin_count),
        .pixel        (pixel),
        .done         (done),
        .mapped_pixel (mapped_pixel)
    );

    always #10 clk = ~clk;

    function automatic pix_t stretch_expected(pix_t p);
        int unsigned span;
        int unsigned offset;
        if (!edge_seen || p < edge_lo)
            return PIX_MIN;
        if (p > edge_hi)
            return PIX_MAX;
        span = edge_hi - edge_lo;
        if (span == 0)
            return PIX_MIN;
        offset = p - edge_lo;
        return pix_t'((510 * offset + span) / (2 * span));
    endfunction

    function automatic void absorb_bin(logic [COUNT_W-1:0] count);
        if (hist_pos == 0)
            edge_seen = 1'b0;
        if (count != 0)
        begin
            if (!edge_seen)
                edge_lo = hist_pos;
            edge_hi   = hist_pos;
            edge_seen = 1'b1;
        end
        if (hist_pos == PIX_MAX)
            passes_done++;
        hist_pos = hist_pos + 1'b1;
    endfunction

    task automatic issue_beat(logic c, logic [COUNT_W-1:0] count, pix_t p, bit typed,
                              pix_t want);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        cmd       <= c;
        bin_count <= count;
        pixel     <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (c == CMD_MAP)
        begin
            pending_pixels.push_back(typed ? want : stretch_expected(p));
            map_count++;
        end
        else
        begin
            absorb_bin(count);
            load_count++;
        end
    endtask

    function automatic logic [COUNT_W-1:0] random_count(int density);
        bit hit;
        case (density)
            0:       hit = 1'b0;
            1:       hit = ($urandom_range(0, 63) == 0);
            2:       hit = ($urandom_range(0, 7) == 0);
            default: hit = ($urandom_range(0, 1) == 0);
        endcase
        if (!hit)
            return '0;
        if ($urandom_range(0, 1) == 0)
            return COUNT_W'(1) << $urandom_range(0, COUNT_W - 1);
        return COUNT_W'($urandom_range(1, (1 << COUNT_W) - 1));
    endfunction

    function automatic pix_t random_pixel();
        case ($urandom_range(0, 3))
            0:       return pix_t'($urandom_range(0, 255));
            1:       return pix_t'($urandom_range(edge_lo, edge_hi));
            2:       return edge_lo + pix_t'($urandom_range(0, 2)) - 1'b1;
            default: return edge_hi + pix_t'($urandom_range(0, 2)) - 1'b1;
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin : check_result
        pix_t want;
        if (rst_n && done)
        begin
            result_count++;
            if (pending_pixels.size() == 0)
            begin
                $error("mapped_pixel: unexpected result, expected none, actual %0d",
                       mapped_pixel);
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (mapped_pixel !== want)
                begin
                    $error("mapped_pixel: expected %0d, actual %0d", want, mapped_pixel);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any beat or result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int base;
        int run_len;
        int density;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
            for (int k = 0; k < DIRECTED_ROWS[r].reps; k++)
                issue_beat(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].count,
                           DIRECTED_ROWS[r].pix, DIRECTED_ROWS[r].typed,
                           DIRECTED_ROWS[r].want);

        // random passes: load runs of varied density interleaved with maps
        base = load_count + map_count;
        while (load_count + map_count - base < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 31) == 0)
                burst = !burst;
            if ($urandom_range(0, 7) == 0)
            begin
                density = $urandom_range(0, 3);
                if ($urandom_range(0, 5) == 0)
                    run_len = 256 - hist_pos;
                else
                    run_len = $urandom_range(1, 24);
                repeat (run_len)
                    issue_beat(CMD_LOAD, random_count(density),
                               pix_t'($urandom_range(0, 255)), 1'b0, PIX_MIN);
            end
            else
                issue_beat(CMD_MAP, COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1)),
                           random_pixel(), 1'b0, PIX_MIN);
        end
        start <= 1'b0;

        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d load beats over %0d full histogram passes and %0d map beats",
                 load_count, passes_done, map_count);
        $display("checked %0d mapped pixels, %0d mismatches", result_count, error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/hcs_pkg.sv
hw/rtl/hcs_edges.sv
hw/rtl/hcs_divider.sv
hw/rtl/histogram_contrast_stretch_top.sv
tb/histogram_contrast_stretch_top_tb.sv
